>>> rtl/ternary_block_transcoder_defines.svh
// Assertion macros for the ternary block transcoder.
`ifndef TERNARY_BLOCK_TRANSCODER_DEFINES_SVH
`define TERNARY_BLOCK_TRANSCODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TBT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ternary_block_transcoder: assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define TBT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ternary_block_transcoder: assertion failed");

`endif

>>> rtl/tbt_pkg.sv
// Package: constants, types and lookup functions of the ternary block transcoder.
`default_nettype none

package tbt_pkg;

    localparam int PackedBytes = 34;
    localparam int TritBytes   = 28;
    localparam int HalfBytes   = 18;
    localparam int OutBytes    = 2 * HalfBytes;
    localparam int ScaleAt     = 26;

    typedef logic [5:0] buf_addr_t;

    typedef struct packed {
        logic [4:0] addr;
        logic [2:0] pow_idx;
    } trit_src_t;

    // Source byte and power of three for trit number n of a 128-trit block.
    function automatic trit_src_t trit_src(input logic [6:0] n);
        trit_src_t  s;
        logic [6:0] m;
        begin
            m = 7'd0;
            if (n < 7'd80)
            begin
                s.addr    = {1'b0, n[3:0]};
                s.pow_idx = n[6:4];
            end
            else if (n < 7'd120)
            begin
                m         = n - 7'd80;
                s.addr    = 5'd16 + {2'b00, m[2:0]};
                s.pow_idx = m[5:3];
            end
            else
            begin
                m         = n - 7'd120;
                s.addr    = 5'd24 + {4'b0000, m[0]};
                s.pow_idx = m[3:1];
            end
            return s;
        end
    endfunction

    function automatic logic [6:0] pow3(input logic [2:0] idx);
        begin
            case (idx)
                3'd0:    return 7'd1;
                3'd1:    return 7'd3;
                3'd2:    return 7'd9;
                3'd3:    return 7'd27;
                default: return 7'd81;
            endcase
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/ternary_block_transcoder.sv
// Ternary block transcoder: byte-stream block unpack and 2-bit repack, top level.
//
// Takes a row of quantized blocks one byte per beat and, for each complete block,
// sends 36 bytes: two 18-byte 2-bit blocks (scale, then 16 data bytes each). A
// byte carrying row_last that does not finish a block yields one error beat
// (out_byte 0, run_last and row_error set) and drops the partial block. Input
// bytes are taken one per cycle while no block is being sent and no output beat
// is stalled. Sending a block runs through a single-port buffer read and one
// shared trit unit (multiply by a power of three, times three, top two bits):
// each byte sent is a read (S_FETCH) then a use (S_USE); a format 1 data byte
// repeats both for each of its four trits, and a send waits on out_ready.
// source_format must be written only while idle; the block does not enforce it.
`default_nettype none
`include "ternary_block_transcoder_defines.svh"

module ternary_block_transcoder
    import tbt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write_en,
    input  wire logic       cfg_write_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       row_last,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            run_last,
    output logic            row_error
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_USE   = 2'd2;

    localparam logic [5:0] LastOut = 6'(OutBytes - 1);

    logic [1:0] state_reg, state_next;
    logic       fmt_reg;
    logic [5:0] count_reg, count_next;
    logic [5:0] k_reg, k_next;
    logic [1:0] t_reg, t_next;
    logic [5:0] acc_reg, acc_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       run_last_reg, run_last_next;
    logic       row_error_reg, row_error_next;

    logic [7:0] buf_mem [PackedBytes];
    logic [7:0] rdata_reg;
    buf_addr_t  rd_addr;

    logic       in_fire;
    logic       out_free;
    logic [6:0] count_inc;
    logic [6:0] blk_size;
    logic       complete;
    logic       is_scale;
    logic       half;
    logic [5:0] data_idx;
    logic [6:0] trit_num;
    trit_src_t  src;
    logic [14:0] prod;
    logic [9:0] tri3;
    logic [1:0] trit;
    logic       byte_done;
    logic [7:0] res_byte;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;
    assign row_error = row_error_reg;

    assign count_inc = {1'b0, count_reg} + 7'd1;
    assign blk_size  = fmt_reg ? 7'(TritBytes) : 7'(PackedBytes);
    assign complete  = count_inc >= blk_size;

    assign is_scale  = (k_reg == 6'd0) || (k_reg == 6'd1)
                    || (k_reg == 6'(HalfBytes)) || (k_reg == 6'(HalfBytes + 1));
    assign half      = k_reg >= 6'(HalfBytes);
    assign data_idx  = half ? (k_reg - 6'(HalfBytes + 2)) : (k_reg - 6'd2);
    assign trit_num  = {half, data_idx[3:0], t_reg};
    assign src       = trit_src(trit_num);

    // Shared trit unit: ((b * 3^p) mod 256) * 3 >> 8
    assign prod      = rdata_reg * {1'b0, pow3(src.pow_idx)};
    assign tri3      = {2'b00, prod[7:0]} + {1'b0, prod[7:0], 1'b0};
    assign trit      = tri3[9:8];

    assign byte_done = !fmt_reg || is_scale || (t_reg == 2'd3);
    assign res_byte  = (!fmt_reg || is_scale) ? rdata_reg : {trit, acc_reg};

    always_comb
    begin
        if (is_scale)
            rd_addr = fmt_reg ? (6'(ScaleAt) + {5'b0, k_reg[0]}) : {5'b0, k_reg[0]};
        else if (fmt_reg)
            rd_addr = {1'b0, src.addr};
        else
            rd_addr = half ? (k_reg - 6'd2) : k_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            buf_mem[count_reg] <= in_byte;
        rdata_reg <= buf_mem[rd_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        t_next         = t_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        run_last_next  = run_last_reg;
        row_error_next = row_error_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (complete)
                    begin
                        count_next = 6'd0;
                        k_next     = 6'd0;
                        t_next     = 2'd0;
                        acc_next   = 6'd0;
                        state_next = S_FETCH;
                    end
                    else if (row_last)
                    begin
                        count_next     = 6'd0;
                        out_valid_next = 1'b1;
                        out_byte_next  = 8'd0;
                        run_last_next  = 1'b1;
                        row_error_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_inc[5:0];
                    end
                end
            end
            S_FETCH:
            begin
                state_next = S_USE;
            end
            S_USE:
            begin
                if (!byte_done)
                begin
                    case (t_reg)
                        2'd0:    acc_next[1:0] = trit;
                        2'd1:    acc_next[3:2] = trit;
                        default: acc_next[5:4] = trit;
                    endcase
                    t_next     = t_reg + 2'd1;
                    state_next = S_FETCH;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = res_byte;
                    run_last_next  = (k_reg == LastOut);
                    row_error_next = 1'b0;
                    t_next         = 2'd0;
                    acc_next       = 6'd0;
                    if (k_reg == LastOut)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 6'd1;
                        state_next = S_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fmt_reg       <= 1'b0;
            count_reg     <= 6'd0;
            k_reg         <= 6'd0;
            t_reg         <= 2'd0;
            acc_reg       <= 6'd0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= 8'd0;
            run_last_reg  <= 1'b0;
            row_error_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_write_en)
                fmt_reg <= cfg_write_data;
            count_reg     <= count_next;
            k_reg         <= k_next;
            t_reg         <= t_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            run_last_reg  <= run_last_next;
            row_error_reg <= row_error_next;
        end
    end

    // error beat always carries zero data and closes its run
    `TBT_ASSERT_NOW(a_err_beat, out_valid_reg && row_error_reg, run_last_reg && (out_byte_reg == 8'd0))
    // block count is cleared whenever a block is being sent
    `TBT_ASSERT_NOW(a_count_clear, state_reg != S_IDLE, count_reg == 6'd0)
    // output index never runs past the last byte of a block
    `TBT_ASSERT_NOW(a_k_range, state_reg != S_IDLE, k_reg <= LastOut)
    // trit step only advances for the base-3 format
    `TBT_ASSERT_NOW(a_trit_fmt, t_reg != 2'd0, fmt_reg)
    // a completing byte starts the send sequence
    `TBT_ASSERT_NEXT(a_start_run, in_fire && complete, state_reg == S_FETCH)

endmodule

`default_nettype wire

>>> test/tbt_block_checker.sv
`timescale 1ns / 1ps
// Ternary block transcoder checker: beat predictor, expected-beat queue and output compare.
package tbt_tb_pkg;

    typedef enum logic
    {
        FmtPacked2 = 1'b0,
        FmtTrit    = 1'b1
    } src_format_t;

endpackage

module tbt_block_checker
    import tbt_pkg::*;
    import tbt_tb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic       cfg_write_data,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       row_last,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_byte,
    input  logic       run_last,
    input  logic       row_error,
    output int         mismatches,
    output int         outstanding,
    output int         blocks_built,
    output int         row_errors
);

    typedef struct packed
    {
        logic [7:0] data;
        logic       last;
        logic       err;
    } dst_beat_t;

    dst_beat_t   expected_beats[$];
    logic [7:0]  held_bytes [PackedBytes];
    int unsigned held_count;
    src_format_t cur_format;

    function automatic logic [1:0] trit_of_byte(input logic [7:0] b, input int unsigned weight);
        int unsigned prod;
        begin
            prod = (b * weight) & 32'hFF;
            return 2'((prod * 3) >> 8);
        end
    endfunction

    // Both 18-byte halves of the destination for the block now held.
    task automatic push_block();
        logic [1:0] trits [128];
        logic [7:0] dst [OutBytes];
        int         n, h, j, g, p, lane, c;
        int unsigned weight;
        int         grp_base  [3] = '{0, 16, 24};
        int         grp_lanes [3] = '{16, 8, 2};
        int         grp_pows  [3] = '{5, 5, 4};
        begin
            if (cur_format == FmtPacked2)
            begin
                for (h = 0; h < 2; h++)
                begin
                    dst[h * HalfBytes]     = held_bytes[0];
                    dst[h * HalfBytes + 1] = held_bytes[1];
                    for (j = 0; j < 16; j++)
                        dst[h * HalfBytes + 2 + j] = held_bytes[2 + 16 * h + j];
                end
            end
            else
            begin
                // lanes within a power, powers within a lane group
                n = 0;
                for (g = 0; g < 3; g++)
                begin
                    weight = 1;
                    for (p = 0; p < grp_pows[g]; p++)
                    begin
                        for (lane = 0; lane < grp_lanes[g]; lane++)
                        begin
                            trits[n] = trit_of_byte(held_bytes[grp_base[g] + lane], weight);
                            n++;
                        end
                        weight = weight * 3;
                    end
                end
                for (h = 0; h < 2; h++)
                begin
                    dst[h * HalfBytes]     = held_bytes[ScaleAt];
                    dst[h * HalfBytes + 1] = held_bytes[ScaleAt + 1];
                    for (j = 0; j < 16; j++)
                    begin
                        c = h * 64 + j * 4;
                        dst[h * HalfBytes + 2 + j] = {trits[c + 3], trits[c + 2],
                                                      trits[c + 1], trits[c]};
                    end
                end
            end
            for (j = 0; j < OutBytes; j++)
                expected_beats.push_back(dst_beat_t'{dst[j], j == OutBytes - 1, 1'b0});
            blocks_built++;
        end
    endtask

    task automatic take_byte(input logic [7:0] b, input logic last);
        int unsigned size;
        begin
            size = (cur_format == FmtTrit) ? TritBytes : PackedBytes;
            if (held_count < PackedBytes)
                held_bytes[held_count] = b;
            held_count++;
            // a format switch mid-block may leave the count past the new size
            if (held_count >= size)
            begin
                held_count = 0;
                push_block();
            end
            else if (last)
            begin
                held_count = 0;
                expected_beats.push_back(dst_beat_t'{8'h00, 1'b1, 1'b1});
                row_errors++;
            end
        end
    endtask

    task automatic check_beat();
        dst_beat_t want;
        begin
            if (expected_beats.size() == 0)
            begin
                $error("unexpected beat: out_byte %0h run_last %0b row_error %0b",
                       out_byte, run_last, row_error);
                mismatches++;
            end
            else
            begin
                want = expected_beats.pop_front();
                if (out_byte !== want.data)
                begin
                    $error("out_byte: expected %0h, got %0h", want.data, out_byte);
                    mismatches++;
                end
                if (run_last !== want.last)
                begin
                    $error("run_last: expected %0b, got %0b", want.last, run_last);
                    mismatches++;
                end
                if (row_error !== want.err)
                begin
                    $error("row_error: expected %0b, got %0b", want.err, row_error);
                    mismatches++;
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_beats.delete();
            held_count   = 0;
            cur_format   = FmtPacked2;
            outstanding  = 0;
            mismatches   = 0;
            blocks_built = 0;
            row_errors   = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                take_byte(in_byte, row_last);
            if (cfg_write_en)
                cur_format = src_format_t'(cfg_write_data);
            if (out_valid && out_ready)
                check_beat();
            outstanding = expected_beats.size();
        end
    end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the ternary block transcoder: clock, reset, stimulus and verdict.
module tb_top;
    import tbt_pkg::*;
    import tbt_tb_pkg::*;

    localparam int SettleCycles = 16;
    localparam int DrainCycles  = 300;
    localparam int RandomBytes  = 230;
    localparam int CalmTail     = 60;

    logic       clk;
    logic       rst_n;
    logic       cfg_write_en;
    logic       cfg_write_data;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       row_last;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       row_error;

    int          mismatches;
    int          outstanding;
    int          blocks_built;
    int          row_errors;
    int          bytes_sent;
    bit          gaps_on;
    bit          stalls_on;
    src_format_t fmt_now;

    ternary_block_transcoder u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_byte        (in_byte),
        .row_last       (row_last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .run_last       (run_last),
        .row_error      (row_error)
    );

    tbt_block_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_byte        (in_byte),
        .row_last       (row_last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .run_last       (run_last),
        .row_error      (row_error),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .blocks_built   (blocks_built),
        .row_errors     (row_errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    function automatic logic [7:0] rand_byte();
        begin
            case ($urandom_range(0, 7))
                0:       return 8'h00;
                1:       return 8'hFF;
                default: return 8'($urandom_range(0, 255));
            endcase
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_byte(input logic [7:0] b, input logic last);
        begin
            if (gaps_on && $urandom_range(0, 3) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            in_valid <= 1'b1;
            in_byte  <= b;
            row_last <= last;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            bytes_sent++;
            @(negedge clk);
        end
    endtask

    // Hold off input until every predicted beat is out, then let the block go quiet.
    task automatic settle();
        begin
            in_valid <= 1'b0;
            while (outstanding != 0)
                @(negedge clk);
            repeat (SettleCycles) @(negedge clk);
        end
    endtask

    task automatic set_format(input src_format_t f);
        begin
            settle();
            cfg_write_en   <= 1'b1;
            cfg_write_data <= f;
            @(negedge clk);
            cfg_write_en   <= 1'b0;
            fmt_now = f;
        end
    endtask

    // Sink stalls in bursts while enabled.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stalls_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    initial
    begin
        int         i, len, kind, size, target;
        bit         noisy;
        logic [7:0] b;

        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = 1'b0;
        in_valid       = 1'b0;
        in_byte        = 8'h00;
        row_last       = 1'b0;
        out_ready      = 1'b0;
        gaps_on        = 1'b0;
        stalls_on      = 1'b0;
        bytes_sent     = 0;
        fmt_now        = FmtPacked2;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        gaps_on   = 1'b1;
        stalls_on = 1'b1;

        // row ends with a lone byte: error beat each
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);

        // 30 bytes held as packed, then switch to trits: next byte overshoots 28
        for (i = 0; i < 30; i++)
        begin
            case (i % 4)
                0:       b = 8'h00;
                1:       b = 8'hFF;
                2:       b = 8'hAB;
                default: b = 8'(i * 53);
            endcase
            send_byte(b, 1'b0);
        end
        set_format(FmtTrit);
        send_byte(8'hAB, 1'b0);

        // 20 trit bytes held, switch back; block completes at 34 with row_last on it
        for (i = 0; i < 20; i++)
            send_byte(rand_byte(), 1'b0);
        set_format(FmtPacked2);
        for (i = 0; i < 14; i++)
            send_byte(rand_byte(), i == 13);

        target = bytes_sent + RandomBytes;
        while (bytes_sent < target)
        begin
            if (bytes_sent > target - CalmTail)
            begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            else
            begin
                gaps_on   = ($urandom_range(0, 4) != 0);
                stalls_on = ($urandom_range(0, 4) != 0);
            end
            if ($urandom_range(0, 3) == 0)
                set_format(src_format_t'($urandom_range(0, 1)));
            size  = (fmt_now == FmtTrit) ? TritBytes : PackedBytes;
            kind  = $urandom_range(0, 9);
            noisy = 1'b0;
            if (kind < 6)
                len = $urandom_range(1, 2) * size;
            else if (kind < 8)
                len = $urandom_range(1, size - 1);
            else
            begin
                len   = $urandom_range(1, 40);
                noisy = 1'b1;
            end
            // every row closes with row_last, so the next row starts aligned
            for (i = 0; i < len; i++)
                send_byte(rand_byte(), (i == len - 1) || (noisy && $urandom_range(0, 5) == 0));
        end

        settle();
        repeat (DrainCycles) @(negedge clk);

        $display("summary: %0d source bytes in, %0d blocks and %0d row-error beats checked",
                 bytes_sent, blocks_built, row_errors);
        $display("summary: both source formats, mid-block format switches, sender and sink stalls");
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/tbt_pkg.sv
rtl/ternary_block_transcoder.sv
test/tbt_block_checker.sv
test/tb_top.sv
